/* design/lrucc_pkg.sv */
// Package for the LRU cache cost counter: shared types, cost constants
// and the key case-folding function. No dependencies.

package lrucc_pkg;

    localparam int KEY_W  = 64;
    localparam int SIZE_W = 6;
    localparam int COST_W = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd3;
    localparam logic [COST_W:0]   COST_HIT   = 33'd1;
    localparam logic [COST_W:0]   COST_MISS  = 33'd5;

    // Control bundle from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;   // capture the match flag for the current word
        logic upd_en;   // apply the recency shift
    } lrucc_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } lrucc_state_t;

    // Fold 'A'..'Z' to 'a'..'z' in each byte, other bytes pass unchanged
    function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic [7:0]       b;
        r = '0;
        for (int i = 0; i < KEY_W / 8; i++) begin
            b = k[8*i +: 8];
            if (b >= 8'h41 && b <= 8'h5A)
            begin
                b = b + 8'h20;
            end
            r[8*i +: 8] = b;
        end
        return r;
    endfunction

endpackage

/* design/lru_cache_cost_counter.sv */
// LRU cache cost counter: a chain of compare-and-shift slots with a small
// sequencer. The result strobe 'done' is registered after the compare and update
// cycles. A lookup takes a compare cycle, then an update cycle, during which the
// next lookup may be accepted. The receiver cannot stall.
// Reset: cost 0, no entries, cache_size 3; slot keys are not cleared.

module lru_cache_cost_counter #(
    parameter int CAPACITY = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [lrucc_pkg::KEY_W-1:0] key,
    input  logic                        restart,
    output logic                        done,
    output logic                        was_hit,
    output logic [lrucc_pkg::COST_W-1:0] total_cost,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lrucc_pkg::SIZE_W-1:0] cfg_data
);
    import lrucc_pkg::*;

    localparam int FILL_W = $clog2(CAPACITY + 1);

    lrucc_state_t       state_reg, state_next;
    logic [KEY_W-1:0]   fkey_reg;
    logic               restart_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [FILL_W-1:0]  eff_reg, eff_next;
    logic [FILL_W-1:0]  size_eff;
    logic [FILL_W-1:0]  new_fill;
    logic [COST_W-1:0]  cost_reg;
    logic [COST_W:0]    cost_sum;
    logic [COST_W-1:0]  cost_next;
    logic               done_reg;
    logic               hit_reg;
    logic               accept;
    logic               hit;
    lrucc_ctrl_t        ctrl;

    logic [KEY_W-1:0]   chain_key [CAPACITY];
    logic [CAPACITY:0]  chain_found;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg == S_CMP);
    assign accept    = start && !busy;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= cfg_data;
        end
    end

    // Effective size is cache_size clipped to the capacity
    assign size_eff = (int'(size_reg) > CAPACITY) ? FILL_W'(CAPACITY)
                                                  : FILL_W'(size_reg);

    // Fill seen by this lookup: cleared on restart, cut to the size
    always_comb
    begin
        eff_next = restart_reg ? '0 : fill_reg;
        if (eff_next > size_eff)
        begin
            eff_next = size_eff;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = start ? S_CMP : S_IDLE;
            S_CMP:   state_next = S_UPD;
            S_UPD:   state_next = start ? S_CMP : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign ctrl.cmp_en = (state_reg == S_CMP);
    assign ctrl.upd_en = (state_reg == S_UPD);

    // Slot chain: keys flow down one slot, match flags flow down as a prefix OR
    assign chain_found[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        lrucc_cell #(
            .INDEX  (i),
            .FILL_W (FILL_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .look_key  (fkey_reg),
            .prev_key  ((i == 0) ? fkey_reg : chain_key[(i == 0) ? 0 : i - 1]),
            .eff_fill  (eff_next),
            .new_fill  (new_fill),
            .found_in  (chain_found[i]),
            .key_out   (chain_key[i]),
            .found_out (chain_found[i+1])
        );
    end

    assign hit = chain_found[CAPACITY];

    // New fill: a miss grows it up to the size, a hit keeps it
    always_comb
    begin
        new_fill = eff_reg;
        if (!hit && eff_reg < size_eff)
        begin
            new_fill = eff_reg + 1'b1;
        end
    end

    // Saturating cost update
    assign cost_sum  = {1'b0, (restart_reg ? '0 : cost_reg)} + (hit ? COST_HIT : COST_MISS);
    assign cost_next = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];

    assign fill_next = new_fill;

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            eff_reg   <= '0;
            cost_reg  <= '0;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ctrl.upd_en;
            if (ctrl.cmp_en)
            begin
                eff_reg <= eff_next;
            end
            if (ctrl.upd_en)
            begin
                fill_reg <= fill_next;
                cost_reg <= cost_next;
                hit_reg  <= hit;
            end
        end
    end

    // Lookup word capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fkey_reg    <= fold_key(key);
            restart_reg <= restart;
        end
    end

    assign done       = done_reg;
    assign was_hit    = hit_reg;
    assign total_cost = cost_reg;

    // Checks
    a_done_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_UPD))
        else $error("result strobe without an update cycle");

    a_cmp_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("compare cycle lasted more than one cycle");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= CAPACITY)
        else $error("fill count beyond capacity");

    a_hit_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.upd_en && hit) |-> (eff_reg != '0))
        else $error("hit with no valid entry");

endmodule

/* design/lrucc_cell.sv */
// One recency slot of the LRU chain: holds a key, compares it, and takes
// its upper neighbor's key on a shift. Depends on lrucc_pkg.

module lrucc_cell #(
    parameter int INDEX  = 0,
    parameter int FILL_W = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lrucc_pkg::lrucc_ctrl_t     ctrl,
    input  logic [lrucc_pkg::KEY_W-1:0] look_key,
    input  logic [lrucc_pkg::KEY_W-1:0] prev_key,
    input  logic [FILL_W-1:0]          eff_fill,
    input  logic [FILL_W-1:0]          new_fill,
    input  logic                       found_in,
    output logic [lrucc_pkg::KEY_W-1:0] key_out,
    output logic                       found_out
);
    import lrucc_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic             match_reg;
    logic             shift;

    // Compare stage: only slots below the fill count can match
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            match_reg <= (key_reg == look_key) && (FILL_W'(INDEX) < eff_fill);
        end
    end

    // Shift when no match sits above this slot and it lies in the new fill
    assign shift = ctrl.upd_en && !found_in && (FILL_W'(INDEX) < new_fill);

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg <= prev_key;
        end
    end

    assign key_out   = key_reg;
    assign found_out = found_in | match_reg;

endmodule
